// File: rtl/smr_pkg.sv
// Shared register map, register widths, reset values and argument side type for the starvation mortality block.
package smr_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_INFLECTION = 2'd0;
    localparam logic [1:0] REG_SCALING    = 2'd1;
    localparam logic [1:0] REG_MAX_RATE   = 2'd2;
    localparam logic [1:0] REG_TIME_SCALE = 2'd3;

    // Register widths.
    localparam int INFL_W  = 16;
    localparam int SCALE_W = 16;
    localparam int RATE_W  = 24;
    localparam int TUS_W   = 32;
    localparam int OUT_W   = 32;

    // Reset values.
    localparam logic [INFL_W-1:0]  INFL_RESET  = 16'd39322;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3277;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd65536;
    localparam logic [TUS_W-1:0]   TUS_RESET   = 32'd65536;

    // Side information carried through the argument divider.
    typedef struct packed {
        logic starving;
        logic neg;
        logic ovf;
    } smr_arg_side_t;

endpackage

// File: rtl/smr_div_pipe.sv
// Pipelined restoring divider that retires one quotient bit per register stage.
module smr_div_pipe
    import smr_pkg::*;
#(
    parameter int DIV_W  = 32,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_bits,
    input  logic [DIV_W-1:0]  in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic [Q_W-1:0]    valid_reg;
    logic [DIV_W-1:0]  rem_reg     [Q_W];
    logic [Q_W-1:0]    bits_reg    [Q_W];
    logic [Q_W-1:0]    quot_reg    [Q_W];
    logic [DIV_W-1:0]  divisor_reg [Q_W];
    logic [SIDE_W-1:0] side_reg    [Q_W];

    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        logic              pvalid;
        logic [DIV_W-1:0]  prem;
        logic [Q_W-1:0]    pbits;
        logic [Q_W-1:0]    pquot;
        logic [DIV_W-1:0]  pdiv;
        logic [SIDE_W-1:0] pside;
        logic [DIV_W:0]    trial;
        logic              ge;
        logic [DIV_W-1:0]  rem_next;

        // Select the previous stage, or the inputs for the first stage.
        if (g == 0)
        begin : g_first
            assign pvalid = in_valid;
            assign prem   = in_rem;
            assign pbits  = in_bits;
            assign pquot  = '0;
            assign pdiv   = in_divisor;
            assign pside  = in_side;
        end
        else
        begin : g_next
            assign pvalid = valid_reg[g-1];
            assign prem   = rem_reg[g-1];
            assign pbits  = bits_reg[g-1];
            assign pquot  = quot_reg[g-1];
            assign pdiv   = divisor_reg[g-1];
            assign pside  = side_reg[g-1];
        end

        // One trial subtraction per stage.
        always_comb
        begin
            trial    = {prem, pbits[Q_W-1]};
            ge       = (trial >= {1'b0, pdiv});
            rem_next = ge ? DIV_W'(trial - {1'b0, pdiv}) : DIV_W'(trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= pvalid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]     <= rem_next;
                bits_reg[g]    <= pbits << 1;
                quot_reg[g]    <= {pquot[Q_W-2:0], ge};
                divisor_reg[g] <= pdiv;
                side_reg[g]    <= pside;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// File: rtl/smr_sigmoid_lut.sv
// Logistic lookup table, built at elaboration, with a registered read.
module smr_sigmoid_lut
    import smr_pkg::*;
#(
    parameter int FRACTION_BITS   = 16,
    parameter int SIGMOID_ENTRIES = 1024,
    parameter int IDX_W           = 10
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     in_starving,
    input  logic [IDX_W-1:0]         in_idx,
    output logic                     out_valid,
    output logic                     out_starving,
    output logic [FRACTION_BITS:0]   out_sig
);

    localparam int EXP_Q        = 30;
    localparam int TAYLOR_TERMS = 24;

    typedef logic [FRACTION_BITS:0] sig_arr_t [SIGMOID_ENTRIES];

    // Unsigned 64-bit quotient by shift and subtract, used only while building the table.
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], a[k]};
            if (rem >= {1'b0, b})
            begin
                rem  = rem - {1'b0, b};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-p/d) in Q0.30 by a truncated Taylor series.
    function automatic logic [63:0] exp_neg_frac(logic [63:0] p, logic [63:0] d);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << EXP_Q;
        pos  = term;
        neg  = '0;
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = udiv64(term * p, d * 64'(k));
            if (k % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // Entry i holds round(2^F / (1 + exp(-16 + 32*i/N))).
    function automatic sig_arr_t build_table();
        sig_arr_t    tbl;
        logic [63:0] n_ent, em1, one, a, b, num, ip, fp, e, den, numer;
        logic        nonneg;
        n_ent = 64'(SIGMOID_ENTRIES);
        em1   = exp_neg_frac(64'd1, 64'd1);
        one   = 64'd1 << EXP_Q;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            a      = 64'd32 * 64'(i);
            b      = 64'd16 * n_ent;
            nonneg = (a >= b);
            num    = nonneg ? a - b : b - a;
            ip     = udiv64(num, n_ent);
            fp     = num - ip * n_ent;
            e      = exp_neg_frac(fp, n_ent);
            for (int j = 0; j < 17; j++)
            begin
                if (64'(j) < ip)
                    e = (e * em1) >> EXP_Q;
            end
            den    = one + e;
            numer  = nonneg ? (e << FRACTION_BITS) : (one << FRACTION_BITS);
            tbl[i] = (FRACTION_BITS+1)'(udiv64(numer + den / 64'd2, den));
        end
        return tbl;
    endfunction

    localparam sig_arr_t SIG_TABLE = build_table();

    logic                   valid_reg;
    logic                   starving_reg;
    logic [FRACTION_BITS:0] sig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Registered table read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            starving_reg <= in_starving;
            sig_reg      <= SIG_TABLE[in_idx];
        end
    end

    assign out_valid    = valid_reg;
    assign out_starving = starving_reg;
    assign out_sig      = sig_reg;

endmodule

// File: rtl/starvation_mortality_logistic.sv
// Top level: configuration registers, ratio and argument dividers, lookup and rate products.
// Throughput: one transaction per cycle while no finished output is held; the two bit-per-stage dividers set the depth.
// The whole pipeline holds while a finished output waits under stall.
// Reset clears all valid bits and loads the configuration registers with their defaults; no clearing pass.
// The logistic table is a constant built at elaboration.
module starvation_mortality_logistic
    import smr_pkg::*;
#(
    parameter int MASS_BITS       = 32,
    parameter int FRACTION_BITS   = 16,
    parameter int SIGMOID_ENTRIES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] body_mass,
    input  logic [31:0] peak_body_mass,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] mortality_rate,
    output logic        starving
);

    localparam int F      = FRACTION_BITS;
    localparam int DW     = (F > INFL_W) ? F : INFL_W;
    localparam int Q2_W   = F + 5;
    localparam int U_W    = F + 6;
    localparam int IDX_W  = $clog2(SIGMOID_ENTRIES);
    localparam int PROD_W = U_W + IDX_W + 1;
    localparam int SIG_W  = F + 1;
    localparam int R1_W   = RATE_W + SIG_W;
    localparam int RATE1_W = R1_W - F;
    localparam int R2_W   = RATE1_W + TUS_W;
    localparam logic [U_W-1:0] LIM = U_W'(16) << F;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SIGMOID_ENTRIES - 1);

    // Configuration registers.
    logic [INFL_W-1:0]  infl_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [TUS_W-1:0]   tus_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            infl_reg  <= INFL_RESET;
            scale_reg <= SCALE_RESET;
            rate_reg  <= RATE_RESET;
            tus_reg   <= TUS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_INFLECTION: infl_reg  <= pwdata[INFL_W-1:0];
                REG_SCALING:    scale_reg <= pwdata[SCALE_W-1:0];
                REG_MAX_RATE:   rate_reg  <= pwdata[RATE_W-1:0];
                REG_TIME_SCALE: tus_reg   <= pwdata[TUS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_INFLECTION: prdata = 32'(infl_reg);
            REG_SCALING:    prdata = 32'(scale_reg);
            REG_MAX_RATE:   prdata = 32'(rate_reg);
            REG_TIME_SCALE: prdata = 32'(tus_reg);
            default:        prdata = '0;
        endcase
    end

    // Global advance: the pipeline moves unless a finished output is held.
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Mass ratio divider: F quotient bits from mass / peak.
    logic [MASS_BITS-1:0] m_in, pk_in;
    logic                 d1_valid;
    logic [F-1:0]         d1_ratio;
    logic                 d1_starving;

    assign m_in  = body_mass[MASS_BITS-1:0];
    assign pk_in = peak_body_mass[MASS_BITS-1:0];

    smr_div_pipe #(
        .DIV_W  (MASS_BITS),
        .Q_W    (F),
        .SIDE_W (1)
    ) u_ratio_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .in_rem     (m_in),
        .in_bits    ('0),
        .in_divisor (pk_in),
        .in_side    (m_in < pk_in),
        .out_valid  (d1_valid),
        .out_quot   (d1_ratio),
        .out_side   (d1_starving)
    );

    // Argument preparation: distance from the inflection and overflow check.
    logic               neg_c;
    logic [DW-1:0]      diff_c;
    logic [SCALE_W-1:0] sc_c;
    logic [DW+F-1:0]    dvd_c;
    logic               prep_valid_reg;
    smr_arg_side_t      prep_side_reg;
    logic [SCALE_W-1:0] prep_rem_reg;
    logic [Q2_W-1:0]    prep_bits_reg;
    logic [SCALE_W-1:0] prep_sc_reg;

    always_comb
    begin
        neg_c  = DW'(d1_ratio) < DW'(infl_reg);
        diff_c = neg_c ? DW'(infl_reg) - DW'(d1_ratio) : DW'(d1_ratio) - DW'(infl_reg);
        sc_c   = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
        dvd_c  = (DW+F)'(diff_c) << F;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_side_reg.starving <= d1_starving;
            prep_side_reg.neg      <= neg_c;
            prep_side_reg.ovf      <= 64'(dvd_c) >= (64'(sc_c) << Q2_W);
            prep_rem_reg           <= SCALE_W'(dvd_c >> Q2_W);
            prep_bits_reg          <= dvd_c[Q2_W-1:0];
            prep_sc_reg            <= sc_c;
        end
    end

    // Argument divider: F+5 quotient bits of distance / scaling.
    logic            d2_valid;
    logic [Q2_W-1:0] d2_quot;
    smr_arg_side_t   d2_side;

    smr_div_pipe #(
        .DIV_W  (SCALE_W),
        .Q_W    (Q2_W),
        .SIDE_W ($bits(smr_arg_side_t))
    ) u_arg_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (prep_valid_reg),
        .in_rem     (prep_rem_reg),
        .in_bits    (prep_bits_reg),
        .in_divisor (prep_sc_reg),
        .in_side    (prep_side_reg),
        .out_valid  (d2_valid),
        .out_quot   (d2_quot),
        .out_side   (d2_side)
    );

    // Clamp the argument and map it to a table index.
    logic [U_W-1:0]    mag_c;
    logic [U_W-1:0]    u_c;
    logic [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0] idx_full_c;
    logic [IDX_W-1:0]  idx_c;
    logic              idx_valid_reg;
    logic              idx_starving_reg;
    logic [IDX_W-1:0]  idx_reg;

    always_comb
    begin
        if (d2_side.ovf || (U_W'(d2_quot) > LIM))
            mag_c = LIM;
        else
            mag_c = U_W'(d2_quot);
        u_c        = d2_side.neg ? LIM - mag_c : LIM + mag_c;
        prod_c     = PROD_W'(u_c) * PROD_W'(SIGMOID_ENTRIES);
        idx_full_c = prod_c >> Q2_W;
        idx_c      = (idx_full_c > PROD_W'(IDX_MAX)) ? IDX_MAX : idx_full_c[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            idx_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_starving_reg <= d2_side.starving;
            idx_reg          <= idx_c;
        end
    end

    // Logistic lookup.
    logic             lut_valid;
    logic             lut_starving;
    logic [SIG_W-1:0] lut_sig;

    smr_sigmoid_lut #(
        .FRACTION_BITS   (F),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES),
        .IDX_W           (IDX_W)
    ) u_lut (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (idx_valid_reg),
        .in_starving  (idx_starving_reg),
        .in_idx       (idx_reg),
        .out_valid    (lut_valid),
        .out_starving (lut_starving),
        .out_sig      (lut_sig)
    );

    // First product: maximum rate times the logistic value.
    logic [R1_W-1:0]    r1_c;
    logic               m1_valid_reg;
    logic               m1_starving_reg;
    logic [RATE1_W-1:0] m1_rate_reg;

    assign r1_c = R1_W'(rate_reg) * R1_W'(lut_sig);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= lut_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_starving_reg <= lut_starving;
            m1_rate_reg     <= r1_c[R1_W-1:F];
        end
    end

    // Second product, saturation and the output register.
    logic [R2_W-1:0]  r2_c;
    logic [R2_W-F-1:0] total_c;
    logic [OUT_W-1:0] sat_c;
    logic [OUT_W-1:0] out_rate_reg;
    logic             out_starving_reg;

    always_comb
    begin
        r2_c    = R2_W'(m1_rate_reg) * R2_W'(tus_reg);
        total_c = r2_c[R2_W-1:F];
        if (total_c > (R2_W-F)'({OUT_W{1'b1}}))
            sat_c = '1;
        else
            sat_c = total_c[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_starving_reg <= m1_starving_reg;
            out_rate_reg     <= m1_starving_reg ? sat_c : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mortality_rate = out_rate_reg;
    assign starving       = out_starving_reg;

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the starvation mortality block: logistic-rate predictor, APB setup, checks.
module tb_top;
    import smr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int N_ENT = 1024;
    localparam int LAT = 42;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic [31:0] body_mass, peak_body_mass;
    logic        out_valid, out_stall;
    logic [31:0] mortality_rate;
    logic        starving;

    starvation_mortality_logistic dut (.*);

    typedef struct {
        logic [31:0] rate;
        logic        starve;
    } rate_exp_t;

    rate_exp_t   rate_queue[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    logic [31:0] logistic_lut[N_ENT];
    logic [15:0] infl_reg;
    logic [15:0] scale_reg;
    logic [23:0] max_rate_reg;
    logic [31:0] time_scale_reg;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // exp(-p/d) in Q0.30 by truncated Taylor series.
    function automatic longint unsigned exp_neg_q30(longint unsigned p, longint unsigned d);
        longint unsigned term, pos, neg;
        term = 64'd1 << 30;
        pos = term;
        neg = 0;
        for (int k = 1; k <= 24; k++)
        begin
            term = (term * p) / (d * k);
            if (k % 2 == 1) neg += term; else pos += term;
        end
        return (pos > neg) ? pos - neg : 0;
    endfunction

    // Build the logistic lookup used for prediction.
    task automatic build_logistic_lut();
        longint unsigned em1, one, a, b, num, ip, fp, e, den, numer;
        bit nonneg;
        em1 = exp_neg_q30(1, 1);
        one = 64'd1 << 30;
        for (int i = 0; i < N_ENT; i++)
        begin
            a = 32 * i;
            b = 16 * N_ENT;
            nonneg = a >= b;
            num = nonneg ? a - b : b - a;
            ip = num / N_ENT;
            fp = num % N_ENT;
            e = exp_neg_q30(fp, N_ENT);
            for (longint unsigned j = 0; j < ip; j++) e = (e * em1) >> 30;
            den = one + e;
            numer = nonneg ? (e << FB) : (one << FB);
            logistic_lut[i] = 32'((numer + den / 2) / den);
        end
    endtask

    // Predict the rate for one cohort.
    function automatic rate_exp_t predict_rate(logic [31:0] m, logic [31:0] pk);
        rate_exp_t res;
        longint unsigned r, rem, diff, sc, mag, lim, u, idx, total;
        bit neg;
        if (!(m < pk))
        begin
            res.rate = '0;
            res.starve = 1'b0;
            return res;
        end
        r = 0;
        rem = m;
        for (int k = 0; k < FB; k++)
        begin
            rem = rem << 1;
            r = r << 1;
            if (rem >= pk)
            begin
                rem -= pk;
                r |= 1;
            end
        end
        neg = r < infl_reg;
        diff = neg ? infl_reg - r : r - infl_reg;
        sc = (scale_reg != 0) ? scale_reg : 1;
        mag = (diff << FB) / sc;
        lim = 64'd16 << FB;
        if (mag > lim) mag = lim;
        u = neg ? lim - mag : lim + mag;
        idx = (u * N_ENT) >> (FB + 5);
        if (idx > N_ENT - 1) idx = N_ENT - 1;
        total = ((max_rate_reg * longint'(logistic_lut[idx])) >> FB);
        total = (total * time_scale_reg) >> FB;
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        res.rate = 32'(total);
        res.starve = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb_top: mismatch: %s", msg);
        error_count++;
    endtask

    // Register write over the configuration port, also updates the predictor copy.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_INFLECTION: infl_reg = value[15:0];
            REG_SCALING:    scale_reg = value[15:0];
            REG_MAX_RATE:   max_rate_reg = value[23:0];
            default:        time_scale_reg = value;
        endcase
    endtask

    task automatic set_config(logic [15:0] infl, logic [15:0] sc, logic [23:0] mr, logic [31:0] ts);
        write_reg(REG_INFLECTION, 32'(infl));
        write_reg(REG_SCALING, 32'(sc));
        write_reg(REG_MAX_RATE, 32'(mr));
        write_reg(REG_TIME_SCALE, ts);
    endtask

    // Send one cohort transaction after a random gap; valid stays high into a zero gap.
    task automatic send_cohort(logic [31:0] m, logic [31:0] pk);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        body_mass      <= m;
        peak_body_mass <= pk;
        do @(posedge clk); while (in_stall);
        rate_queue.push_back(predict_rate(m, pk));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rate_queue.size() != 0) @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    // Random cohort, mostly starving with ratios spread around the curve.
    task automatic send_random_cohort();
        logic [31:0] pk, m;
        pk = $urandom();
        case ($urandom_range(0, 9))
            0: m = $urandom();
            1: m = pk;
            2: m = pk + $urandom_range(0, 1000);
            3: begin pk = $urandom_range(1, 300); m = $urandom_range(0, 300); end
            default: m = 32'((64'(pk) * $urandom_range(0, 65535)) >> 16);
        endcase
        send_cohort(m, pk);
    endtask

    task automatic test_directed();
        send_cohort(32'd0, 32'd0);
        send_cohort(32'd5, 32'd0);
        send_cohort(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cohort(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_cohort(32'd0, 32'hFFFF_FFFF);
        send_cohort(32'd0, 32'd1);
        send_cohort(32'd6, 32'd10);
        send_cohort(32'd59, 32'd100);
        send_cohort(32'd61, 32'd100);
        send_cohort(32'hAAAA_AAAA, 32'hFFFF_FFFF);
        send_cohort(32'h5555_5555, 32'hAAAA_AAAB);
        send_cohort(32'd10, 32'd9);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        // Zero scaling, full rate and full time scale to force saturation.
        set_config(16'd0, 16'd0, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_cohort(32'd0, 32'd100);
        send_cohort(32'd99, 32'd100);
        send_cohort(32'd1, 32'hFFFF_FFFF);
        wait_drained();
        set_config(16'hFFFF, 16'hFFFF, 24'd0, 32'd0);
        send_cohort(32'd1, 32'd2);
        send_cohort(32'd0, 32'd3);
        wait_drained();
        set_config(16'hFFFF, 16'd1, 24'd1, 32'd1);
        send_cohort(32'd1, 32'd2);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_random_cohort();
        wait_drained();
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 4; p++)
        begin
            set_config(16'($urandom()), 16'($urandom()), 24'($urandom()), $urandom());
            test_random(150);
        end
        set_config(INFL_RESET, SCALE_RESET, RATE_RESET, TUS_RESET);
        test_random(300);
    endtask

    // Result checker and receiver stall.
    initial
    begin
        rate_exp_t want;
        int hold;
        out_stall <= 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (rate_queue.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = rate_queue.pop_front();
                    if (mortality_rate !== want.rate)
                        report_mismatch($sformatf("mortality_rate %h want %h",
                                                  mortality_rate, want.rate));
                    if (starving !== want.starve)
                        report_mismatch($sformatf("starving %b want %b", starving,
                                                  want.starve));
                end
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10) : 0;
                out_stall <= (hold > 0);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        body_mass = '0;
        peak_body_mass = '0;
        infl_reg = INFL_RESET;
        scale_reg = SCALE_RESET;
        max_rate_reg = RATE_RESET;
        time_scale_reg = TUS_RESET;
        build_logistic_lut();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random(300);
        test_random_configs();
        wait_drained();
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
